// ----- hdl/perm_unrk_pkg.sv -----
// ----------------------------------------------------------------------------
// perm_unrk_pkg
// Shared widths, pipeline payload types and the factorial table for the
// lexicographic permutation unranking core.
// ----------------------------------------------------------------------------
`default_nettype none

package perm_unrk_pkg;

  localparam int MAX_ELEMENTS = 8;
  localparam int ELEM_W       = 3;
  localparam int POS_W        = 3;
  localparam int CNT_W        = 4;
  localparam int RANK_W       = 16;
  // rank bits retired by one modulo stage
  localparam int MOD_BITS     = 4;
  localparam int MOD_STAGES   = RANK_W / MOD_BITS;

  localparam logic [CNT_W-1:0] CNT_RESET = CNT_W'(MAX_ELEMENTS);

  typedef logic [MAX_ELEMENTS-1:0][ELEM_W-1:0] elem_vec_t;

  // payload of the modulo n! stages
  typedef struct packed {
    logic              vld;
    logic [CNT_W-1:0]  cnt;
    logic [RANK_W-1:0] dvd;
    logic [RANK_W-1:0] rem;
  } mod_pl_t;

  // payload of the digit / selection stages
  typedef struct packed {
    logic              vld;
    logic [CNT_W-1:0]  cnt;
    logic [RANK_W-1:0] rem;
    elem_vec_t         lst;
    elem_vec_t         perm;
  } dig_pl_t;

  // k! for k = 0..8
  function automatic logic [RANK_W-1:0] fact(input logic [CNT_W-1:0] k);
    logic [RANK_W-1:0] f;
    case (k)
      4'd0:    f = 16'd1;
      4'd1:    f = 16'd1;
      4'd2:    f = 16'd2;
      4'd3:    f = 16'd6;
      4'd4:    f = 16'd24;
      4'd5:    f = 16'd120;
      4'd6:    f = 16'd720;
      4'd7:    f = 16'd5040;
      4'd8:    f = 16'd40320;
      default: f = 16'd1;
    endcase
    return f;
  endfunction

  function automatic elem_vec_t identity_list();
    elem_vec_t v;
    for (int i = 0; i < MAX_ELEMENTS; i++) begin
      v[i] = ELEM_W'(i);
    end
    return v;
  endfunction

endpackage

`default_nettype wire

// ----- hdl/perm_unrk_if.sv -----
// ----------------------------------------------------------------------------
// perm_unrk interfaces
// Valid/ready channels: rank requests, permutation results, count writes.
// ----------------------------------------------------------------------------
`default_nettype none

interface perm_unrk_rank_if;
  logic                                valid;
  logic                                ready;
  logic [perm_unrk_pkg::RANK_W-1:0]    rank;
  modport source (output valid, output rank, input ready);
  modport sink   (input valid, input rank, output ready);
endinterface

interface perm_unrk_res_if;
  logic                                valid;
  logic                                ready;
  logic [perm_unrk_pkg::ELEM_W-1:0]    element;
  logic [perm_unrk_pkg::POS_W-1:0]     position;
  logic                                last;
  modport source (output valid, output element, output position, output last,
                  input ready);
  modport sink   (input valid, input element, input position, input last,
                  output ready);
endinterface

interface perm_unrk_cfg_if;
  logic                                valid;
  logic                                ready;
  logic [perm_unrk_pkg::CNT_W-1:0]     data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

// ----- hdl/permutation_unrank_lexicographic_core.sv -----
// ----------------------------------------------------------------------------
// permutation_unrank_lexicographic_core
// Rank in, permutation of 0..n-1 out, one element per beat.
//
//   channel | dir | payload                   | handshake
//   req     | in  | rank[15:0]                | valid/ready
//   res     | out | element, position, last   | valid/ready
//   cfg     | in  | data[3:0] = element_count | valid/ready, ready always 1
//
// Pipeline: 4 stages of rank mod n! (4 bits each), 8 digit/selection stages,
// then the output register.
// The output register sends one element per beat, n elements per item
// (n = element_count clamped to 1..8). Synchronous reset empties the
// pipeline and sets element_count to 8. While the last digit stage holds a
// beat the output register cannot yet take, every stage holds, empty ones too.
// ----------------------------------------------------------------------------
`default_nettype none

module permutation_unrank_lexicographic_core (
  input  wire              clk,
  input  wire              rst,
  perm_unrk_rank_if.sink   req,
  perm_unrk_res_if.source  res,
  perm_unrk_cfg_if.sink    cfg
);
  import perm_unrk_pkg::*;

  logic [CNT_W-1:0] element_count;
  logic [CNT_W-1:0] eff_cnt;
  logic             adv;
  mod_pl_t          mod_pl [MOD_STAGES+1];
  dig_pl_t          dig_pl [MAX_ELEMENTS+1];

  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      element_count <= CNT_RESET;
    end else if (cfg.valid) begin
      element_count <= cfg.data;
    end
  end

  always_comb begin
    eff_cnt = element_count;
    if (element_count == '0) begin
      eff_cnt = 4'd1;
    end else if (element_count > CNT_RESET) begin
      eff_cnt = CNT_RESET;
    end
  end

  assign req.ready = adv;

  always_comb begin
    mod_pl[0].vld = req.valid;
    mod_pl[0].cnt = eff_cnt;
    mod_pl[0].dvd = req.rank;
    mod_pl[0].rem = '0;
  end

  for (genvar g = 0; g < MOD_STAGES; g++) begin : g_mod
    perm_unrk_mod_stage u_mod (
      .clk (clk),
      .rst (rst),
      .adv (adv),
      .d   (mod_pl[g]),
      .q   (mod_pl[g+1])
    );
  end

  always_comb begin
    dig_pl[0].vld  = mod_pl[MOD_STAGES].vld;
    dig_pl[0].cnt  = mod_pl[MOD_STAGES].cnt;
    dig_pl[0].rem  = mod_pl[MOD_STAGES].rem;
    dig_pl[0].lst  = identity_list();
    dig_pl[0].perm = '0;
  end

  for (genvar g = 0; g < MAX_ELEMENTS; g++) begin : g_dig
    perm_unrk_digit_stage u_dig (
      .clk (clk),
      .rst (rst),
      .adv (adv),
      .pos (POS_W'(g)),
      .d   (dig_pl[g]),
      .q   (dig_pl[g+1])
    );
  end

  perm_unrk_emit u_emit (
    .clk (clk),
    .rst (rst),
    .d   (dig_pl[MAX_ELEMENTS]),
    .adv (adv),
    .res (res)
  );

endmodule

`default_nettype wire

// ----- hdl/perm_unrk_mod_stage.sv -----
// ----------------------------------------------------------------------------
// perm_unrk_mod_stage
// Four restoring long-division steps of rank mod n!, then a register.
// ----------------------------------------------------------------------------
`default_nettype none

module perm_unrk_mod_stage (
  input  wire                    clk,
  input  wire                    rst,
  input  wire                    adv,
  input  perm_unrk_pkg::mod_pl_t d,
  output perm_unrk_pkg::mod_pl_t q
);
  import perm_unrk_pkg::*;

  mod_pl_t           nxt;
  logic [RANK_W-1:0] div;
  logic [RANK_W:0]   t;
  logic [RANK_W-1:0] r;
  logic [RANK_W-1:0] sh;

  always_comb begin
    div = fact(d.cnt);
    r   = d.rem;
    sh  = d.dvd;
    t   = '0;
    for (int s = 0; s < MOD_BITS; s++) begin
      // r < div always holds, so one subtract per bit is enough
      t  = {r, sh[RANK_W-1]};
      sh = {sh[RANK_W-2:0], 1'b0};
      if (t >= {1'b0, div}) begin
        t = t - {1'b0, div};
      end
      r = t[RANK_W-1:0];
    end
    nxt     = d;
    nxt.dvd = sh;
    nxt.rem = r;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      q.vld <= 1'b0;
    end else if (adv) begin
      q.vld <= nxt.vld;
    end
    if (adv) begin
      q.cnt <= nxt.cnt;
      q.dvd <= nxt.dvd;
      q.rem <= nxt.rem;
    end
  end

endmodule

`default_nettype wire

// ----- hdl/perm_unrk_digit_stage.sv -----
// ----------------------------------------------------------------------------
// perm_unrk_digit_stage
// One permutation position: factorial-base digit, pick from the unused
// list, close the gap, register.
// ----------------------------------------------------------------------------
`default_nettype none

module perm_unrk_digit_stage (
  input  wire                                clk,
  input  wire                                rst,
  input  wire                                adv,
  input  wire [perm_unrk_pkg::POS_W-1:0]     pos,
  input  perm_unrk_pkg::dig_pl_t             d,
  output perm_unrk_pkg::dig_pl_t             q
);
  import perm_unrk_pkg::*;

  dig_pl_t           nxt;
  logic              active;
  logic [CNT_W-1:0]  left;
  logic [RANK_W-1:0] f;
  logic [RANK_W+1:0] r;
  logic [ELEM_W-1:0] dig;
  elem_vec_t         lst_n;

  always_comb begin
    active = {1'b0, pos} < d.cnt;
    left   = d.cnt - 4'd1 - {1'b0, pos};
    f      = fact({1'b0, left[ELEM_W-1:0]});
    r      = {2'b00, d.rem};
    dig    = '0;
    // digit < 8: three compare/subtract steps against 4f, 2f, f
    for (int b = ELEM_W - 1; b >= 0; b--) begin
      if (r >= ({2'b00, f} << b)) begin
        r      = r - ({2'b00, f} << b);
        dig[b] = 1'b1;
      end
    end
    if (dig > left[ELEM_W-1:0]) begin
      dig = left[ELEM_W-1:0];
    end
    for (int j = 0; j < MAX_ELEMENTS - 1; j++) begin
      lst_n[j] = (ELEM_W'(j) >= dig) ? d.lst[j+1] : d.lst[j];
    end
    lst_n[MAX_ELEMENTS-1] = d.lst[MAX_ELEMENTS-1];

    nxt = d;
    if (active) begin
      nxt.rem       = r[RANK_W-1:0];
      nxt.lst       = lst_n;
      nxt.perm[pos] = d.lst[dig];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      q.vld <= 1'b0;
    end else if (adv) begin
      q.vld <= nxt.vld;
    end
    if (adv) begin
      q.cnt  <= nxt.cnt;
      q.rem  <= nxt.rem;
      q.lst  <= nxt.lst;
      q.perm <= nxt.perm;
    end
  end

endmodule

`default_nettype wire

// ----- hdl/perm_unrk_emit.sv -----
// ----------------------------------------------------------------------------
// perm_unrk_emit
// Output register: holds one finished permutation and sends it out one
// element per beat; stalls the pipeline while it is still sending.
// ----------------------------------------------------------------------------
`default_nettype none

module perm_unrk_emit (
  input  wire                    clk,
  input  wire                    rst,
  input  perm_unrk_pkg::dig_pl_t d,
  output logic                   adv,
  perm_unrk_res_if.source        res
);
  import perm_unrk_pkg::*;

  logic             busy;
  logic [CNT_W-1:0] cnt;
  logic [POS_W-1:0] idx;
  elem_vec_t        perm;
  logic             last_beat;
  logic             beat;
  logic             load;

  always_comb begin
    last_beat = ({1'b0, idx} == (cnt - 4'd1));
    beat      = busy && res.ready;
    load      = d.vld && (!busy || (beat && last_beat));
    adv       = !d.vld || load;
  end

  assign res.valid    = busy;
  assign res.element  = perm[0];
  assign res.position = idx;
  assign res.last     = last_beat;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      idx  <= '0;
    end else if (load) begin
      busy <= 1'b1;
      idx  <= '0;
    end else if (beat) begin
      if (last_beat) begin
        busy <= 1'b0;
      end
      idx <= idx + 3'd1;
    end
    if (load) begin
      cnt  <= d.cnt;
      perm <= d.perm;
    end else if (beat) begin
      perm <= {perm[0], perm[MAX_ELEMENTS-1:1]};
    end
  end

endmodule

`default_nettype wire
